FILE: rtl/core/best_two_disjoint_intervals_assert.svh
// Assertion macros for the interval-selection RTL.
`ifndef BEST_TWO_DISJOINT_INTERVALS_ASSERT_SVH
`define BEST_TWO_DISJOINT_INTERVALS_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define BDI_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a trigger is followed by a condition in the next cycle.
`define BDI_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

FILE: rtl/core/bdi_pkg.sv
// Package with widths, depths and the stored interval type.
package bdi_pkg;
   localparam int MAX_INTERVALS = 1024;
   localparam int ADDR_W = $clog2(MAX_INTERVALS);
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
   localparam int POINT_W = 32;
   localparam int WEIGHT_W = 20;
   localparam int TOTAL_W = 21;

   typedef struct packed {
      logic [POINT_W-1:0]  start_point;
      logic [POINT_W-1:0]  end_point;
      logic [WEIGHT_W-1:0] weight;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } probe_type;
endpackage

FILE: rtl/core/bdi_if.sv
// Request and response channel interfaces.
interface bdi_req_if import bdi_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [POINT_W-1:0]  start_point;
   logic [POINT_W-1:0]  end_point;
   logic [WEIGHT_W-1:0] weight;
   logic                last_item;
   modport source (output valid, start_point, end_point, weight, last_item, input ready);
   modport sink (input valid, start_point, end_point, weight, last_item, output ready);
endinterface

interface bdi_rsp_if import bdi_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TOTAL_W-1:0] best_total;
   logic               overflow;
   modport source (output valid, best_total, overflow, input ready);
   modport sink (input valid, best_total, overflow, output ready);
endinterface

FILE: rtl/core/best_two_disjoint_intervals.sv
// Top level: loads weighted intervals and reports the best single or compatible pair total.
// Requests on req_ch carry one interval each (start, end, weight, last flag).
// Up to 1024 intervals are written to the store, one per cycle, ready high.
// Further intervals are dropped and set the overflow bit of the response.
// The request with last_item high ends the set; ready then drops until the
// response on rsp_ch is taken. The search compares every stored interval with
// every other over the single read port of the store, one read per cycle.
// The response holds best_total and overflow until rsp_ch.ready is high; while
// it waits no request is taken. After the response the store counts from zero.
// Reset (synchronous, active high) empties the store and clears overflow; no
// clearing pass runs, the block is ready in the first cycle after reset.
module best_two_disjoint_intervals import bdi_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   bdi_req_if.sink   req_ch,
   bdi_rsp_if.source rsp_ch
);
   typedef enum logic [2:0] {ST_LOAD, ST_A_RD, ST_A_LAT, ST_SCAN, ST_DONE} state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   a_idx_ff, a_idx_in;
   logic [CNT_W-1:0]   b_idx_ff, b_idx_in;
   entry_type          a_ff, a_in;
   logic [TOTAL_W-1:0] best_ff, best_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;

   logic               req_fire, rsp_fire, wr_en, issue;
   logic [ADDR_W-1:0]  rd_addr;
   entry_type          wr_data, rd_data;
   probe_type          probe;
   logic               cand_valid;
   logic [TOTAL_W-1:0] cand_total;
   logic [CNT_W-1:0]   a_next;

   assign req_ch.ready = (state_ff == ST_LOAD);
   assign rsp_ch.valid = (state_ff == ST_DONE);
   assign rsp_ch.best_total = best_ff;
   assign rsp_ch.overflow = ovf_ff;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign wr_en = req_fire && (count_ff < CNT_W'(MAX_INTERVALS));
   assign wr_data = '{start_point: req_ch.start_point, end_point: req_ch.end_point,
                      weight: req_ch.weight};
   assign issue = (state_ff == ST_SCAN) && (b_idx_ff < count_ff);
   assign rd_addr = (state_ff == ST_A_RD) ? a_idx_ff[ADDR_W-1:0] : b_idx_ff[ADDR_W-1:0];
   assign probe.valid = rd_vld_ff && (rd_idx_ff != a_idx_ff);
   assign probe.entry = rd_data;
   assign a_next = a_idx_ff + CNT_W'(1);

   bdi_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bdi_pair_eval u_pair (
      .clock      (clock),
      .reset      (reset),
      .held       (a_ff),
      .probe      (probe),
      .cand_valid (cand_valid),
      .cand_total (cand_total)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      a_idx_in = a_idx_ff;
      b_idx_in = b_idx_ff;
      a_in = a_ff;
      best_in = best_ff;
      rd_vld_in = issue;
      rd_idx_in = b_idx_ff;
      if (cand_valid && (cand_total > best_ff)) begin
         best_in = cand_total;
      end
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_ch.last_item) begin
                  a_idx_in = '0;
                  best_in = '0;
                  state_in = ST_A_RD;
               end
            end
         end
         ST_A_RD: begin
            state_in = ST_A_LAT;
         end
         ST_A_LAT: begin
            a_in = rd_data;
            // A single interval on its own is a candidate too.
            if (TOTAL_W'(rd_data.weight) > best_ff) begin
               best_in = TOTAL_W'(rd_data.weight);
            end
            b_idx_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (issue) begin
               b_idx_in = b_idx_ff + CNT_W'(1);
            end else if (!rd_vld_ff && !cand_valid) begin
               a_idx_in = a_next;
               state_in = (a_next == count_ff) ? ST_DONE : ST_A_RD;
            end
         end
         ST_DONE: begin
            if (rsp_fire) begin
               count_in = '0;
               ovf_in = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         rd_vld_ff <= rd_vld_in;
      end
      a_idx_ff <= a_idx_in;
      b_idx_ff <= b_idx_in;
      a_ff <= a_in;
      best_ff <= best_in;
      rd_idx_ff <= rd_idx_in;
   end

`include "best_two_disjoint_intervals_assert.svh"

   `BDI_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(MAX_INTERVALS), "store count too large")
   `BDI_ASSERT_ALWAYS(a_no_load_in_search, !(rsp_ch.valid && req_ch.ready), "request while busy")
   `BDI_ASSERT_NEXT(a_clear_after_rsp, rsp_fire, (count_ff == '0) && !ovf_ff, "set not cleared")
   `BDI_ASSERT_NEXT(a_scan_in_range, issue, rd_idx_ff < count_ff, "read beyond loaded intervals")
endmodule

FILE: rtl/core/bdi_store.sv
// Interval memory: one write port and one registered read port.
module bdi_store import bdi_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);
   entry_type mem [MAX_INTERVALS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/bdi_pair_eval.sv
// Pair checker: tests one later interval against the held one and registers the sum.
module bdi_pair_eval import bdi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  entry_type          held,
   input  probe_type          probe,
   output logic               cand_valid,
   output logic [TOTAL_W-1:0] cand_total
);
   logic               cand_valid_ff, cand_valid_in;
   logic [TOTAL_W-1:0] cand_total_ff, cand_total_in;
   logic               order_ok;
   logic               fits;

   // The probe must sort at or after the held interval and start at or after its end.
   assign order_ok = {held.start_point, held.end_point, held.weight}
                     <= {probe.entry.start_point, probe.entry.end_point, probe.entry.weight};
   assign fits = probe.entry.start_point >= held.end_point;
   assign cand_valid_in = probe.valid && order_ok && fits;
   assign cand_total_in = TOTAL_W'(held.weight) + TOTAL_W'(probe.entry.weight);

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_valid_ff <= 1'b0;
      end else begin
         cand_valid_ff <= cand_valid_in;
      end
      cand_total_ff <= cand_total_in;
   end

   assign cand_valid = cand_valid_ff;
   assign cand_total = cand_total_ff;
endmodule

FILE: tb/tb_best_two_disjoint_intervals_scoreboard.sv
// Scoreboard class that predicts the best pair total and checks responses.
class best_pair_scoreboard;
   bit [31:0] set_start[$];
   bit [31:0] set_end[$];
   bit [19:0] set_weight[$];
   bit        set_overflow;
   bit [20:0] total_queue[$];
   bit        overflow_queue[$];
   int        error_count;
   int        response_count;

   function automatic bit [20:0] best_pair_total();
      int n;
      int nx;
      bit [31:0] s[$];
      bit [31:0] e[$];
      bit [19:0] w[$];
      bit [31:0] ts, te;
      bit [19:0] tw;
      bit [20:0] tab[$][3];
      bit [21:0] take;
      bit [20:0] skip;
      n = set_start.size();
      s = set_start;
      e = set_end;
      w = set_weight;
      for (int i = 1; i < n; i++) begin
         for (int j = i; j > 0; j--) begin
            if ({s[j], e[j], w[j]} < {s[j-1], e[j-1], w[j-1]}) begin
               ts = s[j]; te = e[j]; tw = w[j];
               s[j] = s[j-1]; e[j] = e[j-1]; w[j] = w[j-1];
               s[j-1] = ts; e[j-1] = te; w[j-1] = tw;
            end else begin
               break;
            end
         end
      end
      tab = {};
      for (int i = 0; i <= n; i++) tab.push_back('{0, 0, 0});
      for (int i = n - 1; i >= 0; i--) begin
         nx = n;
         for (int p = i + 1; p < n; p++) begin
            if (s[p] >= e[i]) begin
               nx = p;
               break;
            end
         end
         for (int c = 0; c < 2; c++) begin
            skip = tab[i+1][c];
            take = w[i] + tab[nx][c+1];
            if (take > 22'd2097151) take = 22'd2097151;
            tab[i][c] = (take > skip) ? take[20:0] : skip;
         end
      end
      return tab[0][0];
   endfunction

   function void note_request(bit [31:0] s, bit [31:0] e, bit [19:0] w, bit last_item);
      if (set_start.size() < bdi_pkg::MAX_INTERVALS) begin
         set_start.push_back(s);
         set_end.push_back(e);
         set_weight.push_back(w);
      end else begin
         set_overflow = 1;
      end
      if (last_item) begin
         total_queue.push_back(best_pair_total());
         overflow_queue.push_back(set_overflow);
         set_start = {};
         set_end = {};
         set_weight = {};
         set_overflow = 0;
      end
   endfunction

   function void check_response(bit [20:0] total, bit overflow);
      bit [20:0] exp_total;
      bit        exp_overflow;
      response_count++;
      if (total_queue.size() == 0) begin
         $error("Unexpected response: best_total %0d overflow %0d", total, overflow);
         error_count++;
         return;
      end
      exp_total = total_queue.pop_front();
      exp_overflow = overflow_queue.pop_front();
      if (total !== exp_total) begin
         $error("best_total mismatch: expected %0d, actual %0d", exp_total, total);
         error_count++;
      end
      if (overflow !== exp_overflow) begin
         $error("overflow mismatch: expected %0d, actual %0d", exp_overflow, overflow);
         error_count++;
      end
   endfunction

   function int pending();
      return total_queue.size();
   endfunction
endclass

FILE: tb/tb_best_two_disjoint_intervals.sv
// Top module of the testbench for the interval-pair selector.
module tb_best_two_disjoint_intervals;
   import bdi_pkg::*;

   logic clock = 0;
   logic reset = 1;
   bdi_req_if req_ch ();
   bdi_rsp_if rsp_ch ();
   best_pair_scoreboard board;
   int request_count;
   bit sending_done;

   best_two_disjoint_intervals DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.start_point = '0;
      req_ch.end_point = '0;
      req_ch.weight = '0;
      req_ch.last_item = 0;
      rsp_ch.ready = 0;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Holds a request on the channel until the block takes it.
   task automatic send_request(bit [31:0] s, bit [31:0] e, bit [19:0] w, bit last_item);
      int gap;
      gap = gap_length();
      repeat (gap) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.start_point <= s;
      req_ch.end_point <= e;
      req_ch.weight <= w;
      req_ch.last_item <= last_item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(s, e, w, last_item);
      request_count++;
   endtask

   task automatic release_channel();
      req_ch.valid <= 0;
   endtask

   function automatic bit [31:0] rand_point(int span);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom();
      if (r == 1) return 32'hFFFF_FFFF - $urandom_range(0, span);
      return $urandom_range(0, span);
   endfunction

   function automatic bit [19:0] rand_weight();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 20'hFFFFF - $urandom_range(0, 3);
      if (r == 1) return $urandom_range(0, 2);
      return $urandom();
   endfunction

   task automatic send_random_set(int count, int span);
      bit [31:0] s, e;
      for (int k = 0; k < count; k++) begin
         s = rand_point(span);
         if ($urandom_range(0, 7) == 0) e = rand_point(span);
         else e = s + $urandom_range(0, span / 2 + 1);
         send_request(s, e, rand_weight(), k == count - 1);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_response(rsp_ch.best_total, rsp_ch.overflow);
         rsp_ch.ready <= ($urandom_range(0, 99) < 60) ||
                         ($urandom_range(0, 99) < 50 && request_count > 250);
      end
   end

   initial begin
      board = new();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Single intervals at the field extremes.
      send_request(32'h0, 32'h0, 20'h0, 1);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 1);
      // Two touching maximum-weight intervals give the largest total.
      send_request(32'h0, 32'h8000_0000, 20'hFFFFF, 0);
      send_request(32'h8000_0000, 32'hFFFF_FFFF, 20'hFFFFF, 1);
      // Overlapping pair: only one can be chosen.
      send_request(32'd10, 32'd20, 20'd5, 0);
      send_request(32'd15, 32'd30, 20'd7, 1);
      // Inverted interval followed by compatible ones, plus duplicates.
      send_request(32'd100, 32'd50, 20'd9, 0);
      send_request(32'd60, 32'd70, 20'd4, 0);
      send_request(32'd60, 32'd70, 20'd4, 0);
      send_request(32'd40, 32'd45, 20'd11, 0);
      send_request(32'd0, 32'hFFFF_FFFF, 20'd3, 1);
      // Three disjoint intervals: only two may be picked.
      send_request(32'd0, 32'd1, 20'd100, 0);
      send_request(32'd1, 32'd2, 20'd200, 0);
      send_request(32'd2, 32'd3, 20'd300, 1);
      release_channel();
      // Hold the sender off until every response has come back.
      while (board.pending() != 0) @(posedge clock);
      while (request_count < 500) begin
         send_random_set($urandom_range(1, 12), $urandom_range(0, 9) < 7 ? 40 : 100000);
      end
      release_channel();
      sending_done = 1;
   end

   initial begin
      wait (sending_done);
      while (board.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d interval requests and checked %0d totals,", request_count,
               board.response_count);
      $display("including inverted, touching and duplicate intervals.");
      if (board.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      // Stops a run that hangs and reports it as failed.
      #(12 * 500000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
